// ===== hw/rtl/cpfm_pkg.sv =====
`timescale 1ns / 1ps
package cpfm_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int COUNTER_BITS = 16;
  localparam int CH_W         = 1;
  localparam int TICK_W       = 27;
  localparam int PERIOD_W     = COUNTER_BITS + 1;
  localparam int DIV_CNT_W    = $clog2(TICK_W);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [COUNTER_BITS-1:0] capture_value;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]     result_channel;
    logic [PERIOD_W-1:0] period_ticks;
    logic [TICK_W-1:0]   frequency_hz;
  } out_t;

  // one pending measurement between the capture side and the divider
  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [PERIOD_W-1:0] period;
  } job_t;

endpackage

// ===== hw/rtl/capture_pair_frequency_meter.sv =====
`timescale 1ns / 1ps
// Two-channel capture-pair frequency meter.
// in channel: one timer capture per beat (channel, capture_value), valid/ready.
// out channel: one beat per completed pair (result_channel, period_ticks,
//   frequency_hz), valid/ready, from an output register.
// cfg port: cfg_we_i writes tick_rate_hz from cfg_wdata_i; write only when idle.
// A first capture of a pair is stored for its channel and gives no beat.
// A second capture enters a two-entry queue; the divider takes it from there when
// idle, produces one quotient bit per cycle, then loads the output register,
// which raises out_valid_o. The radix-2 divider takes a new pair only after it
// has loaded the last result.
// While the divider runs, the queue absorbs up to two pending pairs; with the
// queue full, in_ready_o drops.
// If the receiver stalls, the result stays in the output register, the next
// division finishes and waits, and the queue then fills.
// Reset clears both channels to waiting for a first capture, empties the
// queue and output, and sets tick_rate_hz to 1000000.
module capture_pair_frequency_meter
  import cpfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_o,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_wdata_i
);

  logic [TICK_W-1:0] tick_rate_q;
  logic              job_push;
  job_t              job_in;
  logic              q_full;
  logic              q_empty;
  job_t              job_out;
  logic              job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RATE_RESET;
    end else if (cfg_we_i) begin
      tick_rate_q <= cfg_wdata_i;
    end
  end

  cpfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .job_valid_o (job_push),
    .job_o       (job_in),
    .job_ready_i (!q_full)
  );

  cpfm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (q_full),
    .pop_i       (job_pop),
    .pop_data_o  (job_out),
    .empty_o     (q_empty)
  );

  cpfm_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_ready_o (job_pop),
    .job_i       (job_out),
    .tick_rate_i (tick_rate_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !q_full)
    else $error("queue push while full");

  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.period_ticks != '0))
    else $error("zero period on output");

  a_freq_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cfg_we_i) |-> (out_o.frequency_hz <= tick_rate_q))
    else $error("frequency above tick rate");
`endif

endmodule

// ===== hw/rtl/cpfm_front.sv =====
`timescale 1ns / 1ps
module cpfm_front
  import cpfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_ready_i
);

  logic [NUM_CHANNELS-1:0] awaiting_q, awaiting_d;
  logic [COUNTER_BITS-1:0] first_q [NUM_CHANNELS];
  logic [COUNTER_BITS-1:0] diff;
  logic                    accept;
  logic                    ch_ok;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ch_ok      = 32'(in_i.channel) < NUM_CHANNELS;

  // wrapped difference; equal captures mean one full counter wrap
  assign diff         = in_i.capture_value - first_q[in_i.channel];
  assign job_o.channel = in_i.channel;
  assign job_o.period  = {~|diff, diff};
  assign job_valid_o   = accept && ch_ok && awaiting_q[in_i.channel];

  always_comb begin
    awaiting_d = awaiting_q;
    if (accept && ch_ok) begin
      awaiting_d[in_i.channel] = ~awaiting_q[in_i.channel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= '0;
    end else begin
      awaiting_q <= awaiting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ch_ok && !awaiting_q[in_i.channel]) begin
      first_q[in_i.channel] <= in_i.capture_value;
    end
  end

endmodule

// ===== hw/rtl/cpfm_queue.sv =====
`timescale 1ns / 1ps
module cpfm_queue
  import cpfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = count_q == CntW'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/cpfm_divider.sv =====
`timescale 1ns / 1ps
module cpfm_divider
  import cpfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  input  logic [TICK_W-1:0] tick_rate_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PERIOD_W:0]    rem_q, rem_d;
  logic [TICK_W-1:0]    quo_q, quo_d;
  logic [PERIOD_W-1:0]  div_q, div_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;
  logic [PERIOD_W:0]    rem_shift;
  logic [PERIOD_W+1:0]  trial;
  logic                 load_out;

  // restoring division, one quotient bit per cycle, msb first
  assign rem_shift = {rem_q[PERIOD_W-1:0], quo_q[TICK_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_q};

  assign job_ready_o = state_q == StIdle;
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          rem_d   = '0;
          quo_d   = tick_rate_i;
          div_d   = job_i.period;
          ch_d    = job_i.channel;
          cnt_d   = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        if (trial[PERIOD_W+1]) begin
          rem_d = rem_shift;
          quo_d = {quo_q[TICK_W-2:0], 1'b0};
        end else begin
          rem_d = trial[PERIOD_W:0];
          quo_d = {quo_q[TICK_W-2:0], 1'b1};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(TICK_W - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          out_valid_d          = 1'b1;
          out_d.result_channel = ch_q;
          out_d.period_ticks   = div_q;
          out_d.frequency_hz   = quo_q;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    ch_q  <= ch_d;
    out_q <= out_d;
  end

endmodule
